/* src/thm_pkg.sv */
// ----------------------------------------------------------------------------
// thm_pkg: shared types and constants of the timer heap manager
// entry layout, cell commands, codes of the word fields and controller states
// ----------------------------------------------------------------------------
package thm_pkg;

  localparam int DEPTH      = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int MAX_EVENTS = 32;
  localparam int EVT_W      = $clog2(MAX_EVENTS + 1);
  localparam int TIME_W     = 48;

  // operation codes of an input word
  localparam logic [1:0] FUNC_ADD  = 2'd0;
  localparam logic [1:0] FUNC_DEL  = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_DEL    = 2'd1;
  localparam logic [1:0] KIND_EXPIRY = 2'd2;

  // result status
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [TIME_W-1:0] expiry;
    logic [31:0]       interval;
    logic              rpt;
    logic [15:0]       module_id;
    logic [31:0]       message;
    logic [15:0]       ident;
  } entry_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_INSERT,
    CMD_DELETE,
    CMD_POP
  } cell_cmd_t;

  // broadcast to every cell of the row
  typedef struct packed {
    cell_cmd_t   cmd;
    logic [15:0] del_ident;
    entry_t      new_entry;
  } cell_ctl_t;

  // passed from a cell to its right neighbor
  typedef struct packed {
    logic place;  // this cell or one to its left takes the new entry
    logic seen;   // the entry being removed is here or to the left
  } link_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_DEL,
    S_CHECK,
    S_REINS
  } state_t;

endpackage

/* src/thm_cell.sv */
// ----------------------------------------------------------------------------
// thm_cell: one slot of the sorted timer row
// holds one entry, shifts right on insert and left on removal
// ----------------------------------------------------------------------------
module thm_cell (
  input  logic              clk,
  input  thm_pkg::cell_ctl_t ctl,
  input  logic              cell_valid,
  input  thm_pkg::entry_t   left_entry,
  input  thm_pkg::entry_t   right_entry,
  input  thm_pkg::link_t    link_in,
  output thm_pkg::link_t    link_out,
  output thm_pkg::entry_t   entry
);
  import thm_pkg::*;

  logic hit;

  // strict compare keeps equal expiries in insertion order
  assign link_out.place = !cell_valid || (entry.expiry > ctl.new_entry.expiry);
  assign hit = (ctl.cmd == CMD_DELETE) && cell_valid && (entry.ident == ctl.del_ident);
  assign link_out.seen = link_in.seen || hit;

  always_ff @(posedge clk) begin
    unique case (ctl.cmd)
      CMD_INSERT: begin
        if (link_in.place) begin
          entry <= left_entry;
        end else if (link_out.place) begin
          entry <= ctl.new_entry;
        end
      end
      CMD_DELETE, CMD_POP: begin
        if (link_out.seen) begin
          entry <= right_entry;
        end
      end
      CMD_NONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

/* src/thm_row.sv */
// ----------------------------------------------------------------------------
// thm_row: row of DEPTH cells kept sorted by expiry
// live entries fill the cells from the left, the head is the earliest
// ----------------------------------------------------------------------------
module thm_row (
  input  logic                       clk,
  input  thm_pkg::cell_ctl_t         ctl,
  input  logic [thm_pkg::CNT_W-1:0]  live_count,
  output thm_pkg::entry_t            head,
  output logic                       found
);
  import thm_pkg::*;

  entry_t cell_entry [DEPTH];
  link_t  link       [DEPTH+1];

  // pop removes the head, so the removal point starts at the first cell
  assign link[0].place = 1'b0;
  assign link[0].seen  = (ctl.cmd == CMD_POP);

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    entry_t left_entry;
    entry_t right_entry;
    logic   cell_valid;

    if (k == 0) begin : g_first
      assign left_entry = ctl.new_entry;
    end else begin : g_mid_l
      assign left_entry = cell_entry[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign right_entry = ctl.new_entry;
    end else begin : g_mid_r
      assign right_entry = cell_entry[k+1];
    end

    assign cell_valid = (CNT_W'(k) < live_count);

    thm_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .cell_valid  (cell_valid),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .link_in     (link[k]),
      .link_out    (link[k+1]),
      .entry       (cell_entry[k])
    );
  end

  assign head  = cell_entry[0];
  assign found = link[DEPTH].seen;

endmodule

/* src/timer_heap_manager_top.sv */
// ----------------------------------------------------------------------------
// timer_heap_manager_top: sorted store of software timers against a ms clock
// add, delete and tick words; expiry events leave in expiry order
// ----------------------------------------------------------------------------
// add and delete: busy in S_ADD or S_DEL while the row acts, and no new word is
//   taken while busy; the answer is then registered onto the result ports
// tick: busy in S_CHECK per expired one-shot timer, S_CHECK and S_REINS per
//   repeating timer (pop, then re-insert through the cell row), S_CHECK to finish;
//   an event strobes after the next S_CHECK, the final one in the first idle cycle
// the receiver cannot stall; rst (synchronous) empties the store, clears the
//   ms and id counters and drops any pending result
module timer_heap_manager_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [31:0] first_delay,
  input  logic [31:0] rearm_period,
  input  logic        repeat_req,
  input  logic [15:0] module_id,
  input  logic [31:0] message_id,
  input  logic [15:0] del_id,
  output logic        strobe,
  output logic [1:0]  kind,
  output logic [1:0]  status,
  output logic [15:0] timer_ident,
  output logic [15:0] dest_module,
  output logic [31:0] dest_message,
  output logic        last
);
  import thm_pkg::*;

  // control state
  state_t            state;
  state_t            state_next;
  logic [TIME_W-1:0] now_ms;
  logic [CNT_W-1:0]  live_count;
  logic [15:0]       next_ident;
  logic              pend_valid;
  logic [EVT_W-1:0]  evt_count;

  // item registers
  entry_t      ins_entry;   // entry to insert: a new add or a re-armed timer
  logic [15:0] del_ident;
  entry_t      pend;        // popped timer whose event waits for its last flag

  // cell row
  cell_ctl_t ctl;
  entry_t    head;
  logic      found;

  logic              accept;
  logic              full;
  logic              due;
  logic [TIME_W-1:0] step;
  entry_t            rearm;

  // result word next values
  logic        strobe_next;
  logic [1:0]  kind_next;
  logic [1:0]  status_next;
  logic [15:0] ident_next;
  logic [15:0] module_next;
  logic [31:0] message_next;
  logic        last_next;

  thm_row u_row (
    .clk        (clk),
    .ctl        (ctl),
    .live_count (live_count),
    .head       (head),
    .found      (found)
  );

  assign accept = start && !busy;
  assign full   = (live_count >= CNT_W'(DEPTH));
  // head is due when it has expired and the per-tick event budget is not spent
  assign due    = (live_count != '0) && (head.expiry <= now_ms)
                  && (evt_count < EVT_W'(MAX_EVENTS));
  // an interval of zero re-arms by one ms
  assign step   = (head.interval == '0) ? TIME_W'(1) : TIME_W'(head.interval);

  // re-armed copy of the head
  always_comb begin
    rearm        = head;
    rearm.expiry = head.expiry + step;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (func == FUNC_ADD) begin
            state_next = S_ADD;
          end else if (func == FUNC_DEL) begin
            state_next = S_DEL;
          end else if (func == FUNC_TICK) begin
            state_next = S_CHECK;
          end
        end
      end
      S_ADD:   state_next = S_IDLE;
      S_DEL:   state_next = S_IDLE;
      S_CHECK: begin
        if (due) begin
          state_next = head.rpt ? S_REINS : S_CHECK;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_REINS: state_next = S_CHECK;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs: row command and result word
  always_comb begin
    busy          = (state != S_IDLE);
    ctl.cmd       = CMD_NONE;
    ctl.del_ident = del_ident;
    ctl.new_entry = ins_entry;
    strobe_next   = 1'b0;
    kind_next     = KIND_ADD;
    status_next   = STATUS_OK;
    ident_next    = ins_entry.ident;
    module_next   = '0;
    message_next  = '0;
    last_next     = 1'b1;
    unique case (state)
      S_IDLE: begin
      end
      S_ADD: begin
        if (!full) begin
          ctl.cmd = CMD_INSERT;
        end
        strobe_next = 1'b1;
        status_next = full ? STATUS_FULL : STATUS_OK;
      end
      S_DEL: begin
        ctl.cmd     = CMD_DELETE;
        strobe_next = 1'b1;
        kind_next   = KIND_DEL;
        status_next = found ? STATUS_OK : STATUS_NOT_FOUND;
        ident_next  = del_ident;
      end
      S_CHECK: begin
        if (due) begin
          ctl.cmd = CMD_POP;
        end
        // previous event goes out once we know whether another follows
        strobe_next  = pend_valid;
        kind_next    = KIND_EXPIRY;
        ident_next   = pend.ident;
        module_next  = pend.module_id;
        message_next = pend.message;
        last_next    = !due;
      end
      S_REINS: begin
        ctl.cmd = CMD_INSERT;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      now_ms     <= '0;
      live_count <= '0;
      next_ident <= '0;
      pend_valid <= 1'b0;
      evt_count  <= '0;
      strobe     <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= strobe_next;
      unique case (state)
        S_IDLE: begin
          if (accept && (func == FUNC_ADD)) begin
            // the id is consumed even if the store turns out full
            next_ident <= next_ident + 16'd1;
          end
          if (accept && (func == FUNC_TICK)) begin
            now_ms     <= now_ms + TIME_W'(1);
            evt_count  <= '0;
            pend_valid <= 1'b0;
          end
        end
        S_ADD: begin
          if (!full) begin
            live_count <= live_count + CNT_W'(1);
          end
        end
        S_DEL: begin
          if (found) begin
            live_count <= live_count - CNT_W'(1);
          end
        end
        S_CHECK: begin
          if (due) begin
            live_count <= live_count - CNT_W'(1);
            evt_count  <= evt_count + EVT_W'(1);
            pend_valid <= 1'b1;
          end else begin
            pend_valid <= 1'b0;
          end
        end
        S_REINS: begin
          live_count <= live_count + CNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept && (func == FUNC_ADD)) begin
      ins_entry.expiry    <= now_ms + TIME_W'(first_delay);
      ins_entry.interval  <= rearm_period;
      ins_entry.rpt       <= repeat_req;
      ins_entry.module_id <= module_id;
      ins_entry.message   <= message_id;
      ins_entry.ident     <= next_ident;
    end else if ((state == S_CHECK) && due) begin
      // re-armed copy goes in behind equal expiries
      ins_entry <= rearm;
    end
    if (accept && (func == FUNC_DEL)) begin
      del_ident <= del_id;
    end
    if ((state == S_CHECK) && due) begin
      pend <= head;
    end
    kind         <= kind_next;
    status       <= status_next;
    timer_ident  <= ident_next;
    dest_module  <= module_next;
    dest_message <= message_next;
    last         <= last_next;
  end

endmodule
